FILE: rtl/nds_pkg.sv
// ============================================================================
// nds_pkg: shared types, constants and table functions
// Widths, fixed-point constants and the sigmoid curve builder used by the
// front, queue and back of the neuron.
// ============================================================================
package nds_pkg;

    localparam int IN_W     = 16;   // Q4.12 operands
    localparam int PROD_W   = 32;   // Q8.24 product
    localparam int ACC_W    = 40;   // Q16.24 accumulator
    localparam int OUT_W    = 16;   // Q0.16 activation
    localparam int P_W      = 29;   // offset sum in [0, 2^28]
    localparam int SEG_SHIFT = 28;  // fraction bits of the scaled sum

    localparam int SIGMOID_SEGMENTS_DEF = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [ACC_W-1:0] ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SUM_LIMIT = ACC_W'(134217728);

    // One queued product together with its end-of-vector mark.
    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic                     last;
    } nds_item_t;

    // Queue occupancy status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } nds_qstat_t;

    // Restoring division, used only while building constant tables.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid at breakpoint i of a curve with segs segments over [-8, +8].
    // e^-t is built from a truncated Taylor series of e^-(t/16), squared four times.
    function automatic logic [OUT_W-1:0] sigmoid_at(input int unsigned i,
                                                    input int unsigned segs);
        logic [63:0] mag;
        logic [63:0] u;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] den;
        logic [63:0] s;
        logic [63:0] one_q31;
        logic        neg;
        one_q31 = 64'd1 << 31;
        neg = (64'(i) * 64'd16) < (64'(segs) * 64'd8);
        mag = neg ? (64'(segs) * 64'd8 - 64'(i) * 64'd16)
                  : (64'(i) * 64'd16 - 64'(segs) * 64'd8);
        u    = udiv64(mag << 31, 64'(segs) * 64'd16);
        sum  = one_q31;
        term = one_q31;
        for (int k = 1; k <= 20; k++) begin
            term = udiv64((term * u) >> 31, 64'(k));
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int k = 0; k < 4; k++) begin
            sum = (sum * sum) >> 31;
        end
        den = one_q31 + sum;
        s   = udiv64((64'd1 << 47) + (den >> 1), den);
        return neg ? OUT_W'(64'd65536 - s) : OUT_W'(s);
    endfunction

endpackage

FILE: rtl/nds_front.sv
// ============================================================================
// nds_front: input beat acceptance and product formation
// Takes one sample/weight beat, forms the Q8.24 product and hands it with
// its last mark to the queue.
// ============================================================================
module nds_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [nds_pkg::IN_W-1:0] s_sample_value,
    input  logic signed [nds_pkg::IN_W-1:0] s_weight_value,
    input  logic                            s_last_element,
    input  nds_pkg::nds_qstat_t             qstat,
    output logic                            push,
    output nds_pkg::nds_item_t              push_item
);
    import nds_pkg::*;

    logic                     valid_reg;
    logic signed [PROD_W-1:0] product_reg;
    logic                     last_reg;
    logic                     accept;

    // The product register frees up whenever its content moves into the queue.
    assign push    = valid_reg && !qstat.full;
    assign s_ready = !valid_reg || !qstat.full;
    assign accept  = s_valid && s_ready;

    assign push_item.product = product_reg;
    assign push_item.last    = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (push) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            product_reg <= PROD_W'(s_sample_value * s_weight_value);
            last_reg    <= s_last_element;
        end
    end

endmodule

FILE: rtl/nds_queue.sv
// ============================================================================
// nds_queue: short product queue
// A small FIFO that decouples product formation from accumulation.
// ============================================================================
module nds_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  nds_pkg::nds_item_t  push_item,
    input  logic                pop,
    output nds_pkg::nds_item_t  head_item,
    output nds_pkg::nds_qstat_t qstat
);
    import nds_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    nds_item_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_item   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/nds_back.sv
// ============================================================================
// nds_back: accumulation and sigmoid pipeline
// Saturating 40-bit accumulation of queued products, then clamp, segment
// scaling, table interpolation and output registering at the end of a vector.
// ============================================================================
module nds_back #(
    parameter int SIGMOID_SEGMENTS = nds_pkg::SIGMOID_SEGMENTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  nds_pkg::nds_item_t               head_item,
    input  nds_pkg::nds_qstat_t              qstat,
    output logic                             pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [nds_pkg::OUT_W-1:0]        m_activation,
    output logic                             m_sum_saturated
);
    import nds_pkg::*;

    localparam int IDX_W = $clog2(SIGMOID_SEGMENTS + 1);
    localparam int Q_W   = SEG_SHIFT + IDX_W;
    localparam logic [Q_W-1:0]   SEG_Q   = Q_W'(SIGMOID_SEGMENTS);
    localparam logic [IDX_W-1:0] SEG_IDX = IDX_W'(SIGMOID_SEGMENTS);
    localparam int FP_W = OUT_W + SEG_SHIFT;

    // Sigmoid breakpoints, built at elaboration.
    logic [OUT_W-1:0] curve [SIGMOID_SEGMENTS + 1];
    for (genvar g = 0; g <= SIGMOID_SEGMENTS; g++) begin : g_curve
        localparam logic [OUT_W-1:0] CV = sigmoid_at(g, SIGMOID_SEGMENTS);
        assign curve[g] = CV;
    end

    logic adv;
    assign adv = !m_valid || m_ready;
    assign pop = adv && !qstat.empty;

    // Accumulator stage.
    logic signed [ACC_W-1:0] acc_reg;
    logic                    ovf_reg;
    logic signed [ACC_W:0]   sum_wide;
    logic                    ovf_now;
    logic signed [ACC_W-1:0] acc_next;

    assign sum_wide = $signed({acc_reg[ACC_W-1], acc_reg}) + (ACC_W + 1)'(head_item.product);
    assign ovf_now  = sum_wide[ACC_W] != sum_wide[ACC_W-1];
    assign acc_next = ovf_now ? (sum_wide[ACC_W] ? ACC_MIN : ACC_MAX) : sum_wide[ACC_W-1:0];

    // Pipeline registers.
    logic                    v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic signed [ACC_W-1:0] sum1_reg;
    logic                    sat1_reg, sat2_reg, sat3_reg, sat4_reg, m_sat_reg;
    logic [P_W-1:0]          p2_reg;
    logic [Q_W-1:0]          q3_reg;
    logic [OUT_W-1:0]        y0_4_reg;
    logic [OUT_W-1:0]        frac4_reg;
    logic [OUT_W-1:0]        act_reg;

    // Clamp to [-8, +8] and offset into [0, 2^28].
    logic                    clamp_hi, clamp_lo;
    logic signed [ACC_W-1:0] sum_c;
    logic signed [ACC_W-1:0] sum_off;
    assign clamp_hi = sum1_reg > SUM_LIMIT;
    assign clamp_lo = sum1_reg < -SUM_LIMIT;
    assign sum_c    = clamp_hi ? SUM_LIMIT : (clamp_lo ? -SUM_LIMIT : sum1_reg);
    assign sum_off  = sum_c + SUM_LIMIT;

    // Segment index and linear interpolation.
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     idx_p1;
    logic [SEG_SHIFT-1:0] rem;
    logic                 at_end;
    logic [OUT_W-1:0]     y0, y1, diff;
    logic [FP_W-1:0]      frac_prod;
    logic [FP_W-1:0]      frac_round;
    assign idx        = q3_reg[Q_W-1:SEG_SHIFT];
    assign rem        = q3_reg[SEG_SHIFT-1:0];
    assign at_end     = idx >= SEG_IDX;
    assign idx_p1     = idx + 1'b1;
    assign y0         = at_end ? curve[SIGMOID_SEGMENTS] : curve[idx];
    assign y1         = at_end ? curve[SIGMOID_SEGMENTS] : curve[idx_p1];
    assign diff       = y1 - y0;
    assign frac_prod  = FP_W'(diff) * FP_W'(rem);
    assign frac_round = frac_prod + FP_W'(1 << (SEG_SHIFT - 1));

    logic [OUT_W:0] y_sum;
    assign y_sum = {1'b0, y0_4_reg} + {1'b0, frac4_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (head_item.last) begin
                    acc_reg <= '0;
                    ovf_reg <= 1'b0;
                end else begin
                    acc_reg <= acc_next;
                    ovf_reg <= ovf_reg || ovf_now;
                end
            end
            if (adv) begin
                v1_reg      <= pop && head_item.last;
                v2_reg      <= v1_reg;
                v3_reg      <= v2_reg;
                v4_reg      <= v3_reg;
                m_valid_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum1_reg  <= acc_next;
            sat1_reg  <= ovf_reg || ovf_now;
            p2_reg    <= sum_off[P_W-1:0];
            sat2_reg  <= sat1_reg || clamp_hi || clamp_lo;
            q3_reg    <= Q_W'(Q_W'(p2_reg) * SEG_Q);
            sat3_reg  <= sat2_reg;
            y0_4_reg  <= y0;
            frac4_reg <= at_end ? '0 : frac_round[FP_W-1:SEG_SHIFT];
            sat4_reg  <= sat3_reg;
            act_reg   <= y_sum[OUT_W] ? {OUT_W{1'b1}} : y_sum[OUT_W-1:0];
            m_sat_reg <= sat4_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_activation    = act_reg;
    assign m_sum_saturated = m_sat_reg;

endmodule

FILE: rtl/neuron_dot_product_sigmoid.sv
// ============================================================================
// neuron_dot_product_sigmoid: one neuron's forward pass
// Weighted sum of Q4.12 sample/weight beats into a saturating accumulator,
// followed by a table-interpolated logistic sigmoid per vector.
// ============================================================================
// The block takes one sample/weight beat per clock cycle for as long as the
// result side keeps up, and returns one Q0.16 activation beat for each beat
// that carries last_element. Each input beat is multiplied in the front into
// a Q8.24 product, which waits in a four-entry queue until the single
// accumulator stage folds it into the 40-bit saturating sum; that one
// multiply-accumulate per cycle sets the sustained rate of one beat per cycle.
// After the last beat of a vector the sum is clamped to plus or minus 8,
// scaled onto the sigmoid segment table and linearly interpolated over four
// further stages, the last of which is the output register, while the next
// vector already accumulates.
// sum_saturated is high when the accumulator hit its limit at any point of
// that vector or the final sum lay outside plus or minus 8. A held result
// stalls the back part; the queue and front register then absorb up to five
// beats before s_ready drops. The sigmoid table has SIGMOID_SEGMENTS segments
// and is built when the design elaborates; no vector length is enforced.
// ============================================================================
module neuron_dot_product_sigmoid #(
    parameter int SIGMOID_SEGMENTS = nds_pkg::SIGMOID_SEGMENTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [nds_pkg::IN_W-1:0] s_sample_value,
    input  logic signed [nds_pkg::IN_W-1:0] s_weight_value,
    input  logic                            s_last_element,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nds_pkg::OUT_W-1:0]       m_activation,
    output logic                            m_sum_saturated
);
    import nds_pkg::*;

    // Front to queue.
    logic       push;
    nds_item_t  push_item;
    // Queue to back.
    logic       pop;
    nds_item_t  head_item;
    nds_qstat_t qstat;

    // Front: accepts each beat and forms its product.
    nds_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_weight_value (s_weight_value),
        .s_last_element (s_last_element),
        .qstat          (qstat),
        .push           (push),
        .push_item      (push_item)
    );

    // Queue: lets the front keep taking beats while the back is stalled.
    nds_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    // Back: accumulation, clamp, table lookup and the output register.
    nds_back #(
        .SIGMOID_SEGMENTS (SIGMOID_SEGMENTS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_item       (head_item),
        .qstat           (qstat),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_activation    (m_activation),
        .m_sum_saturated (m_sum_saturated)
    );

    // The front never pushes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !qstat.full)
        else $error("product pushed into a full queue");

    // The back never pops an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !qstat.empty)
        else $error("product popped from an empty queue");

    // A result can follow a popped item only once the pipeline has drained it:
    // no result is shown in the cycle right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid directly after reset");

endmodule

FILE: bench/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for neuron_dot_product_sigmoid
// Streams sample/weight beats into the neuron, predicts each activation with
// an independent fixed-point model of the accumulator and sigmoid curve, and
// compares every returned beat under random source and sink idling.
// ============================================================================
module tb_top;

    import nds_pkg::*;

    // Sigmoid table size. It matches the default that the block elaborates with.
    localparam int SEGMENTS = SIGMOID_SEGMENTS_DEF;

    // Accumulator limits and the +/-8 clamp of the sum, all in Q.24.
    localparam longint ACC_HIGH  = 64'sd549755813887;
    localparam longint ACC_LOW   = -64'sd549755813888;
    localparam longint SUM_CLAMP = 64'sd134217728;
    localparam longint unsigned ONE_Q31 = 64'd2147483648;

    // The watchdog gives up after this many cycles without any beat moving.
    // The longest legitimate quiet stretch is a drain pause plus the pipeline
    // latency plus a random stall run, which is far shorter.
    localparam int QUIET_LIMIT = 4000;

    // Cycles to keep watching the result side once nothing is expected.
    localparam int TAIL_CYCLES = 24;

    // One activation beat as the neuron should return it.
    typedef struct {
        logic [OUT_W-1:0] activation;
        logic             saturated;
    } activation_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the running weighted sum, turns each completed vector
    // into an expected activation, and checks returned beats in order.
    // ------------------------------------------------------------------------
    class neuron_scoreboard;
        longint            running_sum;
        bit                overflow_hit;
        longint unsigned   curve_points [0:SEGMENTS];
        activation_beat_t  pending_activations [$];
        int                failures;

        function new();
            running_sum  = 0;
            overflow_hit = 1'b0;
            failures     = 0;
            for (int i = 0; i <= SEGMENTS; i++) begin
                curve_points[i] = breakpoint_level(i);
            end
        endfunction

        // Sigmoid at breakpoint i, in Q0.16. e^-|x| comes from a truncated
        // series of e^-(|x|/16) in Q1.31, squared four times.
        function longint unsigned breakpoint_level(int unsigned i);
            longint          offset;
            longint unsigned mag;
            longint unsigned u;
            longint unsigned series;
            longint unsigned term;
            longint unsigned denom;
            longint unsigned level;
            bit              below_zero;
            offset     = 16 * longint'(i) - 8 * longint'(SEGMENTS);
            below_zero = offset < 0;
            mag        = below_zero ? longint'(-offset) : offset;
            u          = (mag << 31) / (64'd16 * SEGMENTS);
            series     = ONE_Q31;
            term       = ONE_Q31;
            for (int k = 1; k <= 20; k++) begin
                term = ((term * u) >> 31) / longint'(k);
                if (k % 2 == 1) begin
                    series = series - term;
                end else begin
                    series = series + term;
                end
            end
            for (int k = 0; k < 4; k++) begin
                series = (series * series) >> 31;
            end
            denom = ONE_Q31 + series;
            level = ((64'd1 << 47) + denom / 2) / denom;
            return below_zero ? 64'd65536 - level : level;
        endfunction

        // Folds one accepted beat into the sum; a last beat yields an activation.
        function void take_beat(logic signed [IN_W-1:0] sample_in,
                                logic signed [IN_W-1:0] weight_in,
                                logic                   last_in);
            longint           total;
            longint           clamped;
            longint unsigned  scaled;
            longint unsigned  seg;
            longint unsigned  frac;
            longint unsigned  level;
            bit               clipped;
            activation_beat_t beat;
            total = running_sum + longint'(sample_in) * longint'(weight_in);
            if (total > ACC_HIGH) begin
                total        = ACC_HIGH;
                overflow_hit = 1'b1;
            end else if (total < ACC_LOW) begin
                total        = ACC_LOW;
                overflow_hit = 1'b1;
            end
            running_sum = total;
            if (!last_in) begin
                return;
            end
            clamped = total;
            clipped = 1'b0;
            if (clamped > SUM_CLAMP) begin
                clamped = SUM_CLAMP;
                clipped = 1'b1;
            end else if (clamped < -SUM_CLAMP) begin
                clamped = -SUM_CLAMP;
                clipped = 1'b1;
            end
            scaled = longint'(clamped + SUM_CLAMP) * longint'(SEGMENTS);
            seg    = scaled >> SEG_SHIFT;
            frac   = scaled & ((64'd1 << SEG_SHIFT) - 1);
            if (seg >= SEGMENTS) begin
                level = curve_points[SEGMENTS];
            end else begin
                level = curve_points[seg] + (((curve_points[seg + 1] - curve_points[seg])
                        * frac + (64'd1 << (SEG_SHIFT - 1))) >> SEG_SHIFT);
            end
            if (level > 65535) begin
                level = 65535;
            end
            beat.activation = level[OUT_W-1:0];
            beat.saturated  = overflow_hit || clipped;
            pending_activations.push_back(beat);
            running_sum  = 0;
            overflow_hit = 1'b0;
        endfunction

        // Compares a returned beat with the oldest expected activation.
        function void check_result(logic [OUT_W-1:0] activation_in, logic saturated_in);
            activation_beat_t want;
            if (pending_activations.size() == 0) begin
                $error("activation: expected none, got %0d", activation_in);
                failures++;
                return;
            end
            want = pending_activations.pop_front();
            if (activation_in !== want.activation) begin
                $error("activation: expected %0d, got %0d", want.activation, activation_in);
                failures++;
            end
            if (saturated_in !== want.saturated) begin
                $error("sum_saturated: expected %0d, got %0d", want.saturated, saturated_in);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_activations.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [IN_W-1:0] s_sample_value = '0;
    logic signed [IN_W-1:0] s_weight_value = '0;
    logic                   s_last_element = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_W-1:0]       m_activation;
    logic                   m_sum_saturated;

    neuron_dot_product_sigmoid uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_value  (s_sample_value),
        .s_weight_value  (s_weight_value),
        .s_last_element  (s_last_element),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_activation    (m_activation),
        .m_sum_saturated (m_sum_saturated)
    );

    // 20-unit clock period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    neuron_scoreboard sb = new();

    // Idle percentages for the two sides; the main sequence changes them per phase.
    int unsigned send_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned beats_sent     = 0;
    int unsigned quiet_cycles   = 0;

    // ------------------------------------------------------------------------
    // Result side. A beat is taken at an edge where m_valid and m_ready were
    // both high just before it; m_ready for the next cycle is drawn in the
    // same step, so a stall can begin in any phase of the pipeline.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_activation, m_sum_saturated);
        end
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Source side.
    // ------------------------------------------------------------------------

    // Presents one beat, with optional idle cycles ahead of it, and holds it
    // until the block takes it. Returns in the step of the accepting edge.
    task automatic send_beat(logic signed [IN_W-1:0] sample_in,
                             logic signed [IN_W-1:0] weight_in,
                             logic                   last_in);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_value <= sample_in;
        s_weight_value <= weight_in;
        s_last_element <= last_in;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.take_beat(sample_in, weight_in, last_in);
        beats_sent++;
    endtask

    // Stops sending and waits until every expected activation has returned.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Operand drawn according to a value mix. Small values keep the sum inside
    // +/-8 so the interpolation is exercised; full-range and corner values
    // drive the clamp and toggle every bit.
    function automatic logic signed [IN_W-1:0] pick_operand(int unsigned mix);
        logic signed [IN_W-1:0] corners [5] = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};
        if (mix < 50) begin
            return IN_W'($signed($urandom_range(0, 8191)) - 4096);
        end else if (mix < 75) begin
            return IN_W'($urandom);
        end else if (mix < 90) begin
            return corners[$urandom_range(0, 4)];
        end
        return ($urandom_range(0, 1) == 1) ? IN_W'($urandom)
                                           : IN_W'($signed($urandom_range(0, 2047)) - 1024);
    endfunction

    // One vector of random length and content. Most vectors are short; about
    // a quarter are longer to exercise extended accumulation.
    task automatic send_random_vector();
        int unsigned mix;
        int unsigned length;
        mix    = $urandom_range(0, 99);
        length = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int n = 0; n < length; n++) begin
            send_beat(pick_operand(mix), pick_operand(mix), n == length - 1);
        end
    endtask

    // A vector long enough to drive the 40-bit accumulator into saturation:
    // 513 near-full-scale products of one sign, then a random last beat.
    task automatic send_saturating_vector(bit toward_negative);
        logic signed [IN_W-1:0] sample_in;
        logic signed [IN_W-1:0] weight_in;
        for (int n = 0; n < 513; n++) begin
            sample_in = IN_W'(-32768 + $urandom_range(0, 3));
            weight_in = toward_negative ? 16'sh7FFF : 16'sh8000;
            send_beat(sample_in, weight_in, 1'b0);
        end
        send_beat(IN_W'($urandom), IN_W'($urandom), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // First phase: the source rarely idles while the sink stalls heavily,
        // so results back up and the block has to push back on s_ready.
        send_idle_pct  = 9;
        sink_stall_pct = 87;

        // Directed vectors. Single-beat vectors first: a zero sum, the most
        // positive and negative products (both clamp), a sum of exactly +8 and
        // -8 (no clamp), slightly beyond +8, the smallest nonzero products and
        // a sum on a segment breakpoint.
        send_beat(16'sd0, 16'sd0, 1'b1);
        send_beat(16'sh8000, 16'sh8000, 1'b1);
        send_beat(16'sh8000, 16'sh7FFF, 1'b1);
        send_beat(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_beat(16'sd8192, 16'sd16384, 1'b1);
        send_beat(-16'sd8192, 16'sd16384, 1'b1);
        send_beat(16'sd8192, 16'sd16385, 1'b1);
        send_beat(16'sd1, 16'sd1, 1'b1);
        send_beat(-16'sd1, 16'sd1, 1'b1);
        send_beat(16'sd4096, 16'sd1024, 1'b1);
        // Two beats that cancel to zero.
        send_beat(16'sd4096, 16'sd4096, 1'b0);
        send_beat(-16'sd4096, 16'sd4096, 1'b1);
        // Several beats that pass beyond +8 and come back inside; the clamp
        // only looks at the final sum.
        send_beat(16'sh7FFF, 16'sd16384, 1'b0);
        send_beat(16'sh7FFF, 16'sd16384, 1'b0);
        send_beat(16'sh8000, 16'sd16384, 1'b0);
        send_beat(16'sh8000, 16'sd16384, 1'b0);
        send_beat(16'sd2048, 16'sd4096, 1'b1);
        // A negative sum inside the range, across three beats.
        send_beat(-16'sd12288, 16'sd4096, 1'b0);
        send_beat(16'sd1000, -16'sd3000, 1'b0);
        send_beat(16'sd5, 16'sd7, 1'b1);

        // The source holds off here until every activation has come back,
        // so the pipeline runs empty once before the random part.
        drain_results();

        while (beats_sent < 170) begin
            send_random_vector();
        end
        drain_results();

        // Second phase: the source idles most cycles and the sink rarely
        // stalls, so the pipeline runs mostly starved.
        send_idle_pct  = 87;
        sink_stall_pct = 9;
        while (beats_sent < 340) begin
            send_random_vector();
        end
        drain_results();

        // Last phase: no idling on either side, full throughput. Both
        // accumulator saturation directions are driven here, followed by
        // random vectors that check the sum and overflow mark were cleared.
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        send_saturating_vector(1'b0);
        send_random_vector();
        send_saturating_vector(1'b1);
        while (beats_sent < 1450) begin
            send_random_vector();
        end

        // Wait for the last activations, then keep watching a little longer
        // for any spurious result beat.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
